>>> hw/rtl/isrt_pkg.sv
// Shared types and constants for the insertion sorter.
// No dependencies; imported by isrt_cell, insertion_sorter and tb_top.
`timescale 1ns / 1ps
`default_nettype none

package isrt_pkg;

  // Width of the value field on both stream channels.
  localparam int unsigned VALUE_W = 32;

  // Per-cycle command broadcast from the top level to every cell.
  typedef struct packed {
    logic ins;  // insert the arriving word into the sorted row
    logic pop;  // shift the row one place toward cell 0 (result taken)
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/isrt_cell.sv
// One compare-and-shift cell of the sorting row.
// Depends on isrt_pkg for the cell command struct.
`timescale 1ns / 1ps
`default_nettype none

module isrt_cell #(
  parameter int unsigned WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire isrt_pkg::cell_ctl_t   ctl,
  input  wire logic [WIDTH-1:0]      new_val,
  input  wire logic [WIDTH-1:0]      left_val,
  input  wire logic                  left_valid,
  input  wire logic                  left_gt,
  input  wire logic [WIDTH-1:0]      right_val,
  input  wire logic                  right_valid,
  output logic                       gt,
  output logic [WIDTH-1:0]           val,
  output logic                       valid
);
  import isrt_pkg::*;

  logic [WIDTH-1:0] val_r, val_nxt;
  logic             vld_r, vld_nxt;
  logic             take;

  // Strictly greater, so equal values keep their arrival order.
  assign gt = vld_r && ($signed(val_r) > $signed(new_val));

  // A cell takes a word when its own entry moves right, or when it is the
  // first free slot behind the insertion point.
  assign take = gt || (!vld_r && (left_gt || left_valid));

  always_comb begin
    val_nxt = val_r;
    vld_nxt = vld_r;
    if (ctl.pop) begin
      val_nxt = right_val;
      vld_nxt = right_valid;
    end else if (ctl.ins && take) begin
      val_nxt = left_gt ? left_val : new_val;
      vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    val_r <= val_nxt;
  end

  assign val   = val_r;
  assign valid = vld_r;

endmodule

`default_nettype wire

>>> hw/rtl/insertion_sorter.sv
// Top level of the insertion sorter: a row of DEPTH isrt_cell instances
// plus load/drain control. Depends on isrt_pkg and isrt_cell.
//
//   Channel | Direction | tdata               | tlast    | tuser
//   in_     | slave     | [31:0] value        | last     | -
//   out_    | master     | [31:0] value_res    | last_res | [0] overflow
//
// Loading takes one word per cycle; each word is compared against every cell
// in parallel and the row shifts right behind the insertion point.
// After the word with tlast, the n sorted results leave from cell 0, one per
// cycle while out_tready is high, as the row shifts left; in_tready is low
// until the last result has left. Words arriving with the row full are
// dropped and set overflow on every result of that list.
// Reset empties the row; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module insertion_sorter #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [isrt_pkg::VALUE_W-1:0] in_tdata,   // [31:0] value
  input  wire logic                        in_tlast,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [isrt_pkg::VALUE_W-1:0]     out_tdata,  // [31:0] value_res
  output logic                             out_tlast,
  output logic                             out_tuser   // [0] overflow
);
  import isrt_pkg::*;

  localparam int unsigned XW = (WIDTH > VALUE_W) ? WIDTH : VALUE_W;

  logic             drain_r, drain_nxt;
  logic             ovf_r, ovf_nxt;
  logic             in_acc, out_acc, full;
  cell_ctl_t        ctl;
  logic [XW-1:0]    in_ext, out_ext;
  logic [WIDTH-1:0] new_val;

  logic [WIDTH-1:0] val [DEPTH];
  logic             vld [DEPTH];
  logic             gt  [DEPTH];

  // Input bits above WIDTH are ignored; narrow values leave zero-extended.
  assign in_ext  = XW'(in_tdata);
  assign new_val = in_ext[WIDTH-1:0];
  assign out_ext = XW'(val[0]);

  assign in_tready = !drain_r;
  assign in_acc    = in_tvalid && in_tready;
  assign full      = vld[DEPTH-1];

  assign out_tvalid = drain_r && vld[0];
  assign out_tdata  = out_ext[VALUE_W-1:0];
  assign out_tlast  = vld[0] && !vld[1];
  assign out_tuser  = ovf_r;
  assign out_acc    = out_tvalid && out_tready;

  assign ctl.ins = in_acc && !full;
  assign ctl.pop = out_acc;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WIDTH-1:0] l_val, r_val;
    logic             l_vld, l_gt, r_vld;

    if (i == 0) begin : g_head
      assign l_val = '0;
      assign l_vld = 1'b1;
      assign l_gt  = 1'b0;
    end else begin : g_mid
      assign l_val = val[i-1];
      assign l_vld = vld[i-1];
      assign l_gt  = gt[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign r_val = '0;
      assign r_vld = 1'b0;
    end else begin : g_body
      assign r_val = val[i+1];
      assign r_vld = vld[i+1];
    end

    isrt_cell #(.WIDTH(WIDTH)) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .new_val     (new_val),
      .left_val    (l_val),
      .left_valid  (l_vld),
      .left_gt     (l_gt),
      .right_val   (r_val),
      .right_valid (r_vld),
      .gt          (gt[i]),
      .val         (val[i]),
      .valid       (vld[i])
    );
  end

  always_comb begin
    drain_nxt = drain_r;
    ovf_nxt   = ovf_r;
    if (in_acc) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end
      if (in_tlast) begin
        drain_nxt = 1'b1;
      end
    end
    // The final word of the list leaves: back to loading, flag cleared.
    if (out_acc && out_tlast) begin
      drain_nxt = 1'b0;
      ovf_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drain_r <= 1'b0;
      ovf_r   <= 1'b0;
    end else begin
      drain_r <= drain_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// Self-checking bench for insertion_sorter: sends signed lists, predicts the sorted output
// words and the overflow flag, and checks every result word under random idling.
// Depends on isrt_pkg and the insertion_sorter RTL.
`timescale 1ns / 1ps

module tb_top;
  import isrt_pkg::*;

  localparam int unsigned DEPTH = 64;
  localparam int QUIET_LIMIT = 5000;

  typedef logic signed [VALUE_W-1:0] elem_t;

  typedef struct {
    elem_t value;
    logic  last;
    logic  overflow;
  } sorted_word_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [VALUE_W-1:0] in_tdata = '0;   // [31:0] value
  logic               in_tlast = 1'b0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [VALUE_W-1:0] out_tdata;       // [31:0] value_res
  logic               out_tlast;
  logic               out_tuser;       // [0] overflow

  // Current list as the block should hold it, in ascending order.
  elem_t        list_store[$];
  logic         list_dropped = 1'b0;
  sorted_word_t expected_sorted_q[$];

  int error_count = 0;
  int quiet_cycles = 0;
  int sender_idle_pct = 0;
  int recv_stall_pct = 0;

  insertion_sorter #(
    .DEPTH(DEPTH),
    .WIDTH(VALUE_W)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // A new word goes behind every stored word that is not greater, so ties keep
  // their arrival order. The closing word releases the whole list.
  function automatic void insert_element(elem_t v, logic last);
    int           pos;
    sorted_word_t w;
    if (list_store.size() >= DEPTH) begin
      list_dropped = 1'b1;
    end else begin
      pos = list_store.size();
      while (pos > 0 && list_store[pos-1] > v) pos--;
      list_store.insert(pos, v);
    end
    if (last) begin
      foreach (list_store[i]) begin
        w.value    = list_store[i];
        w.last     = (i == list_store.size() - 1);
        w.overflow = list_dropped;
        expected_sorted_q.push_back(w);
      end
      list_store.delete();
      list_dropped = 1'b0;
    end
  endfunction

  function automatic elem_t rand_element();
    case ($urandom_range(9))
      0:       return {1'b1, {(VALUE_W-1){1'b0}}};
      1:       return {1'b0, {(VALUE_W-1){1'b1}}};
      2, 3, 4: return $signed($urandom_range(8)) - 4;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_word(elem_t v, logic last);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    insert_element(v, last);
  endtask

  task automatic send_list(int len);
    for (int i = 0; i < len; i++) send_word(rand_element(), i == len - 1);
  endtask

  task automatic test_extremes_and_ties();
    send_word({1'b1, {(VALUE_W-1){1'b0}}}, 1'b1);
    send_word({1'b0, {(VALUE_W-1){1'b1}}}, 1'b1);
    send_word({1'b0, {(VALUE_W-1){1'b1}}}, 1'b0);
    send_word(0, 1'b0);
    send_word(-1, 1'b0);
    send_word({1'b1, {(VALUE_W-1){1'b0}}}, 1'b0);
    send_word(1, 1'b0);
    send_word(-1, 1'b0);
    send_word(elem_t'(32'h5555_5555), 1'b0);
    send_word(elem_t'(32'hAAAA_AAAA), 1'b1);
    for (int i = 0; i < 3; i++) send_word(7, i == 2);
    for (int i = 5; i > 0; i--) send_word(i, i == 1);
  endtask

  // A list that just fills the row, then one whose tail words, the closing one
  // included, arrive with the row full and must be dropped.
  task automatic test_full_store();
    send_list(DEPTH);
    send_list(DEPTH + 2);
  endtask

  task automatic test_random_lists(int n_words);
    int sent;
    int len;
    int r;
    sent = 0;
    while (sent < n_words) begin
      r = $urandom_range(99);
      if (r < 85) len = $urandom_range(12, 1);
      else if (r < 95) len = $urandom_range(DEPTH, 13);
      else len = $urandom_range(DEPTH + 8, DEPTH + 1);
      send_list(len);
      sent += len;
    end
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : check_results
    sorted_word_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_sorted_q.size() == 0) begin
        $error("unexpected result word: value_res %0d", $signed(out_tdata));
        error_count++;
      end else begin
        w = expected_sorted_q.pop_front();
        if (out_tdata !== w.value) begin
          $error("value_res: expected %0d, got %0d", w.value, $signed(out_tdata));
          error_count++;
        end
        if (out_tlast !== w.last) begin
          $error("last_res: expected %0b, got %0b", w.last, out_tlast);
          error_count++;
        end
        if (out_tuser !== w.overflow) begin
          $error("overflow: expected %0b, got %0b", w.overflow, out_tuser);
          error_count++;
        end
      end
    end
  end

  // Ends a hung run: counts cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_extremes_and_ties();

    sender_idle_pct = 26;
    recv_stall_pct  = 26;
    test_full_store();

    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    test_random_lists(70);
    sender_idle_pct = 72;
    recv_stall_pct  = 0;
    test_random_lists(70);
    sender_idle_pct = 0;
    recv_stall_pct  = 72;
    test_random_lists(70);
    sender_idle_pct = 26;
    recv_stall_pct  = 26;
    test_random_lists(70);

    in_tvalid <= 1'b0;
    while (expected_sorted_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
